// ----- src/lbp_texture_bin_counter_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef LBP_TEXTURE_BIN_COUNTER_MACROS_SVH
`define LBP_TEXTURE_BIN_COUNTER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define LBP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in %m");

// Check a property on every rising edge, reset included.
`define LBP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed in %m");

`endif

// ----- src/lbp_pkg.sv -----
package lbp_pkg;

    // Frame size limits and derived widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;
    localparam int PIX_W      = 8;
    localparam int CODE_W     = 8;
    localparam int NUM_BINS   = 1 << CODE_W;
    localparam int TOTAL_W    = CODE_W + 1;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // Size register reset values
    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 11'd480;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef t_pix [8:0]        t_win;
    typedef logic [CODE_W-1:0] t_code;

    // Request from the window stage to the bin tracker
    typedef struct packed {
        logic  step;       // an item leaves the window stage
        logic  mark;       // flag the code of this item
        logic  frame_end;  // last item of the frame
        t_code code;
    } t_bin_req;

    // Map a size register into 1..maxv
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] res;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Pattern code of the window centre; window index 0 is the top-left,
    // 4 the centre, 8 the bottom-right
    function automatic t_code lbp_code(input t_win w);
        t_code c;
        c[0] = w[0] > w[4];
        c[1] = w[1] > w[4];
        c[2] = w[2] > w[4];
        c[3] = w[5] > w[4];
        c[4] = w[8] > w[4];
        c[5] = w[7] > w[4];
        c[6] = w[6] > w[4];
        c[7] = w[3] > w[4];
        return c;
    endfunction

endpackage

// ----- src/lbp_bins.sv -----
module lbp_bins
    import lbp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_bin_req           i_req,
    output logic [TOTAL_W-1:0] o_total_next
);

    logic [NUM_BINS-1:0] r_seen;
    logic [TOTAL_W-1:0]  r_total;
    logic                is_new;

    // Count the code when it was not seen yet in this frame
    assign is_new       = i_req.mark && !r_seen[i_req.code];
    assign o_total_next = r_total + TOTAL_W'(is_new);

    // Hold flags and total; drop both at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_total <= '0;
        end else if (i_req.step) begin
            if (i_req.frame_end) begin
                r_seen  <= '0;
                r_total <= '0;
            end else begin
                if (i_req.mark) begin
                    r_seen[i_req.code] <= 1'b1;
                end
                r_total <= o_total_next;
            end
        end
    end

endmodule

// ----- src/lbp_texture_bin_counter.sv -----
// An accepted item goes through the window stage; at frame end its result is loaded
// into the output register. Throughput: one pixel per cycle unless a frame result meets
// a full output; the line store is read at accept time and written when the item leaves
// the window stage, with a bypass for a read of the address just written.
// Reset (synchronous, active low) clears position, window, bin flags and output;
// size registers return to 640 x 480. Line stores are not cleared.
module lbp_texture_bin_counter
    import lbp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_gray_pixel,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [TOTAL_W-1:0]   o_occupied_bins,
    // configuration write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    localparam int LINE_W = 2 * PIX_W;

    // Size registers
    logic [SIZE_W-1:0] r_frame_width;
    logic [SIZE_W-1:0] r_frame_height;
    logic [SIZE_W-1:0] width_eff;
    logic [SIZE_W-1:0] height_eff;

    // Raster position of the next item
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic              col_last;
    logic              row_last;

    // Line store: {older row, newer row} per column
    logic [LINE_W-1:0] r_line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] r_rd;
    logic              r_fwd;
    logic [LINE_W-1:0] r_fwd_data;
    logic [LINE_W-1:0] rd_eff;

    // Window stage
    logic              r_s1_valid;
    logic [COL_W-1:0]  r_s1_col;
    t_pix              r_s1_pix;
    logic              r_s1_first;
    logic              r_s1_interior;
    logic              r_s1_end;
    t_win              r_win;
    t_win              n_win;
    t_code             code;

    // Output register
    logic               r_out_valid;
    logic [TOTAL_W-1:0] r_out_data;

    logic               s1_adv;
    logic               s1_take;
    logic               accept;
    t_bin_req           bin_req;
    logic [TOTAL_W-1:0] total_next;

    assign o_cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_WIDTH;
            r_frame_height <= RESET_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign width_eff  = clamp_size(r_frame_width, SIZE_W'(MAX_WIDTH));
    assign height_eff = clamp_size(r_frame_height, SIZE_W'(MAX_HEIGHT));
    assign col_last   = (SIZE_W'(r_col) + SIZE_W'(1)) >= width_eff;
    assign row_last   = (SIZE_W'(r_row) + SIZE_W'(1)) >= height_eff;

    // Handshake: the window stage moves unless a frame result meets a full output
    assign s1_adv     = !r_s1_valid || !r_s1_end || !r_out_valid || !i_out_stall;
    assign s1_take    = r_s1_valid && s1_adv;
    assign accept     = i_in_valid && s1_adv;
    assign o_in_stall = !s1_adv;

    // Advance the raster position on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (!col_last) begin
                r_col <= r_col + COL_W'(1);
            end else begin
                r_col <= '0;
                if (!row_last) begin
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_row <= '0;
                end
            end
        end
    end

    // Line data seen by the window stage, with bypass of the last write
    assign rd_eff = r_fwd ? r_fwd_data : r_rd;

    // Read line store at accept, write back when the item leaves the window stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd       <= r_line_mem[r_col];
            r_fwd_data <= {rd_eff[PIX_W-1:0], r_s1_pix};
        end
        if (s1_take) begin
            r_line_mem[r_s1_col] <= {rd_eff[PIX_W-1:0], r_s1_pix};
        end
    end

    // Mark a read that hits the address written in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (accept) begin
            r_fwd <= s1_take && (r_s1_col == r_col);
        end
    end

    // Load the window stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept || (r_s1_valid && !s1_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col      <= r_col;
            r_s1_pix      <= i_gray_pixel;
            r_s1_first    <= (r_col == '0) && (r_row == '0);
            r_s1_interior <= (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
            r_s1_end      <= col_last && row_last;
        end
    end

    // Shift the window one column left; the new column enters on the right
    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = rd_eff[LINE_W-1:PIX_W];
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = rd_eff[PIX_W-1:0];
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_take) begin
            r_win <= n_win;
        end
    end

    assign code = lbp_code(n_win);

    // Flag border code on the first pixel, pattern code on interior pixels
    always_comb begin
        bin_req.step      = s1_take;
        bin_req.mark      = r_s1_first || r_s1_interior;
        bin_req.frame_end = r_s1_end;
        bin_req.code      = r_s1_interior ? code : '0;
    end

    lbp_bins u_bins (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (bin_req),
        .o_total_next (total_next)
    );

    // Hold the frame result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_take && r_s1_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take && r_s1_end) begin
            r_out_data <= total_next;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_occupied_bins = r_out_data;

endmodule

// ----- src/lbp_checker.sv -----
`include "lbp_texture_bin_counter_macros.svh"

module lbp_checker
    import lbp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_gray_pixel,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  logic [TOTAL_W-1:0]   o_occupied_bins,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    // A stalled result stays valid and unchanged
    `LBP_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_occupied_bins))

    // Every frame holds border pixels, so the count is at least one
    `LBP_ASSERT(a_count_nonzero, i_clk, i_rst_n, o_out_valid |-> o_occupied_bins != '0)

    // The count never exceeds the number of codes
    `LBP_ASSERT(a_count_range, i_clk, i_rst_n, o_out_valid |-> o_occupied_bins <= TOTAL_W'(NUM_BINS))

    // No result right after reset
    `LBP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind lbp_texture_bin_counter lbp_checker u_lbp_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import lbp_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_PIXELS = 350;

    typedef enum int {TEX_UNIFORM, TEX_NARROW, TEX_BINARY, TEX_MIDGRAY} t_texture;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [PIX_W-1:0]     i_gray_pixel = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [TOTAL_W-1:0]   o_occupied_bins;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SIZE_W-1:0]    i_cfg_data = '0;

    // Pixels waiting to be offered and bin counts waiting to come back
    t_pix               pixel_queue[$];
    logic [TOTAL_W-1:0] bins_expected[$];

    // Frame size as the block holds it
    logic [SIZE_W-1:0] cfg_width = RESET_WIDTH;
    logic [SIZE_W-1:0] cfg_height = RESET_HEIGHT;

    // Texture tracker state
    t_pix              older_row[MAX_WIDTH] = '{default: '0};
    t_pix              newer_row[MAX_WIDTH] = '{default: '0};
    t_pix              win[9] = '{default: '0};
    bit [NUM_BINS-1:0] bins_hit = '0;
    int                hit_count = 0;
    int                col_pos = 0;
    int                row_pos = 0;

    int   mismatches = 0;
    int   cycle_count = 0;
    int   hold_left = 0;
    bit   hold_taken = 1'b0;
    bit   long_hold_req = 1'b0;
    bit   steady = 1'b0;

    lbp_texture_bin_counter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_gray_pixel    (i_gray_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_occupied_bins (o_occupied_bins),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Map a size register to the size in effect: zero acts as one, saturate at the top
    function automatic int effective_size(input logic [SIZE_W-1:0] v, input int limit);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > limit) begin
            return limit;
        end
        return int'(v);
    endfunction

    function automatic void flag_code(input t_code c);
        if (!bins_hit[c]) begin
            bins_hit[c] = 1'b1;
            hit_count++;
        end
    endfunction

    // Advance the texture tracker by one pixel; queue the bin count at frame end
    function automatic void predict_pixel(input t_pix pix);
        int    w;
        int    h;
        t_pix  ctr;
        t_code c;
        w = effective_size(cfg_width, MAX_WIDTH);
        h = effective_size(cfg_height, MAX_HEIGHT);

        // slide the window left, new column from the line stores and the pixel
        for (int r = 0; r < 3; r++) begin
            win[r*3]     = win[r*3 + 1];
            win[r*3 + 1] = win[r*3 + 2];
        end
        win[2] = older_row[col_pos];
        win[5] = newer_row[col_pos];
        win[8] = pix;
        older_row[col_pos] = newer_row[col_pos];
        newer_row[col_pos] = pix;

        // border code is flagged with the first pixel of every frame
        if (col_pos == 0 && row_pos == 0) begin
            flag_code('0);
        end

        if (col_pos >= 2 && row_pos >= 2) begin
            ctr  = win[4];
            c[0] = win[0] > ctr;
            c[1] = win[1] > ctr;
            c[2] = win[2] > ctr;
            c[3] = win[5] > ctr;
            c[4] = win[8] > ctr;
            c[5] = win[7] > ctr;
            c[6] = win[6] > ctr;
            c[7] = win[3] > ctr;
            flag_code(c);
        end

        if (col_pos + 1 < w) begin
            col_pos++;
        end else begin
            col_pos = 0;
            if (row_pos + 1 < h) begin
                row_pos++;
            end else begin
                bins_expected.push_back(TOTAL_W'(hit_count));
                row_pos   = 0;
                bins_hit  = '0;
                hit_count = 0;
            end
        end
    endfunction

    function automatic t_pix texture_pixel(input t_texture tex);
        case (tex)
            TEX_NARROW:  return t_pix'($urandom_range(3));
            TEX_BINARY:  return $urandom_range(1) ? '1 : '0;
            TEX_MIDGRAY: return t_pix'(126 + $urandom_range(4));
            default:     return t_pix'($urandom_range(255));
        endcase
    endfunction

    // Pixel driver: offer the next item once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            i_gray_pixel <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_pixel(i_gray_pixel);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pixel_queue.size() > 0 && (steady || $urandom_range(99) >= 19)) begin
                    i_in_valid   <= 1'b1;
                    i_gray_pixel <= pixel_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each bin count, stall at random or for one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (bins_expected.size() == 0) begin
                    $error("occupied_bins: no result expected, actual %0d", o_occupied_bins);
                    mismatches <= mismatches + 1;
                end else begin
                    if (o_occupied_bins !== bins_expected[0]) begin
                        $error("occupied_bins: expected %0d, actual %0d",
                               bins_expected[0], o_occupied_bins);
                        mismatches <= mismatches + 1;
                    end
                    void'(bins_expected.pop_front());
                end
            end
            if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (long_hold_req && !hold_taken) begin
                hold_left   <= HOLD_CYCLES;
                hold_taken  <= 1'b1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !steady && ($urandom_range(99) < 19);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  cfg_width = data;
            CFG_FRAME_HEIGHT: cfg_height = data;
            default: ;
        endcase
    endtask

    task automatic set_frame_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
    endtask

    // Hold until every pixel is taken and every count has come, then let the pipe settle
    task automatic wait_drained();
        @(negedge i_clk);
        while (pixel_queue.size() > 0 || i_in_valid || bins_expected.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_frames(input int frames, input t_texture tex, output int pushed);
        int n;
        n = effective_size(cfg_width, MAX_WIDTH) * effective_size(cfg_height, MAX_HEIGHT);
        pushed = n * frames;
        @(negedge i_clk);
        repeat (pushed) pixel_queue.push_back(texture_pixel(tex));
    endtask

    initial begin
        t_pix     star[9] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        int       random_items;
        int       pushed;
        int       frames;
        t_texture tex;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Dark centre among bright neighbours: all eight bits set, plus the border code
        set_frame_size(11'd3, 11'd3);
        @(negedge i_clk);
        foreach (star[k]) pixel_queue.push_back(star[k]);
        wait_drained();

        // Zero sizes act as one: a single border pixel
        set_frame_size(11'd0, 11'd0);
        @(negedge i_clk);
        pixel_queue.push_back(8'h80);
        wait_drained();

        // Narrow the frame partway through its second row, then finish that frame
        set_frame_size(11'd4, 11'd4);
        @(negedge i_clk);
        repeat (6) pixel_queue.push_back(texture_pixel(TEX_UNIFORM));
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 11'd3);
        @(negedge i_clk);
        repeat (7) pixel_queue.push_back(texture_pixel(TEX_NARROW));
        wait_drained();

        // Long output hold while small frames keep coming, so the input backs up
        set_frame_size(11'd3, 11'd3);
        @(negedge i_clk);
        long_hold_req = 1'b1;
        queue_frames(24, TEX_UNIFORM, pushed);
        wait_drained();

        // Wider frame, streamed without gaps on either side
        set_frame_size(11'd32, 11'd5);
        @(negedge i_clk);
        steady = 1'b1;
        queue_frames(1, TEX_UNIFORM, pushed);
        wait_drained();
        @(negedge i_clk);
        steady = 1'b0;

        // Random frame sizes and textures
        random_items = 0;
        while (random_items < RANDOM_PIXELS) begin
            case ($urandom_range(9))
                0:       w = SIZE_W'($urandom_range(2));
                1:       w = SIZE_W'($urandom_range(33, 10));
                default: w = SIZE_W'($urandom_range(8, 3));
            endcase
            h = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(2))
                                         : SIZE_W'($urandom_range(7, 3));
            frames = $urandom_range(3, 1);
            tex = t_texture'($urandom_range(3));
            set_frame_size(w, h);
            queue_frames(frames, tex, pushed);
            random_items += pushed;
            wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && bins_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
